// ===== hdl/jdisp_pkg.sv =====
// jdisp_pkg: sizes, codes and controller/datapath command types of the job dispatcher
// no dependencies; imported by every other file of the block

package jdisp_pkg;

	// sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_WORKERS = 8;

	// field widths
	localparam int CFG_W    = 4;
	localparam int ACTION_W = 2;
	localparam int JOB_W    = 16;
	localparam int WORKER_W = 3;
	localparam int STATUS_W = 4;

	// derived widths
	localparam int QIW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int SIW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int ICW = $clog2(MAX_WORKERS + 1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD      = 2'd0,
		ACT_RETRACT  = 2'd1,
		ACT_RETURN   = 2'd2,
		ACT_SHUTDOWN = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_DISPATCHED = 4'd0,
		STS_QUEUED     = 4'd1,
		STS_ABANDONED  = 4'd2,
		STS_INVALID    = 4'd3,
		STS_RETRACTED  = 4'd4,
		STS_NOT_FOUND  = 4'd5,
		STS_IGNORED    = 4'd6,
		STS_IDLE       = 4'd7,
		STS_FULL       = 4'd8,
		STS_SHUTDOWN   = 4'd9
	} status_t;

	// source of the job field of a result
	typedef enum logic [1:0] {
		JSEL_NONE  = 2'd0,
		JSEL_ITEM  = 2'd1,
		JSEL_QUEUE = 2'd2,
		JSEL_HOLD  = 2'd3
	} job_sel_t;

	// source of the worker field of a result
	typedef enum logic [1:0] {
		WSEL_NONE  = 2'd0,
		WSEL_ITEM  = 2'd1,
		WSEL_STACK = 2'd2
	} worker_sel_t;

	// controller to datapath
	typedef struct packed {
		logic        latch;        // capture the accepted word
		logic        res_load;     // load the output register
		status_t     res_status;
		job_sel_t    res_job_sel;
		worker_sel_t res_worker_sel;
		logic        res_last;
		logic        pop_idle;     // take the worker on top of the idle stack
		logic        push_idle;    // put the returning worker on the idle stack
		logic        enqueue;      // append the job to the queue
		logic        walk_init;    // start a pass over the queue
		logic        init_idx_one; // pass starts at entry one
		logic        init_found;   // gap already open at entry zero
		logic        hold_capture; // keep the head job
		logic        walk_step;    // advance the pass by one entry
		logic        shift_write;  // move the current entry down by one
		logic        set_found;
		logic        cnt_dec;
		logic        cnt_clear;
		logic        set_dying;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		action_t action;
		logic    job_zero;
		logic    dying;
		logic    idle_empty;
		logic    queue_full;
		logic    queue_empty;
		logic    walk_end;
		logic    found;
		logic    match;
		logic    out_free;
	} sts_t;

endpackage

// ===== hdl/jdisp_item_if.sv =====
// jdisp_item_if: handshake channel for input words of the job dispatcher
// depends on jdisp_pkg for field widths

interface jdisp_item_if import jdisp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [JOB_W-1:0]    job_id;
	logic [WORKER_W-1:0] worker;

	modport source (output valid, output action, output job_id, output worker, input ready);
	modport sink (input valid, input action, input job_id, input worker, output ready);
endinterface

// ===== hdl/jdisp_result_if.sv =====
// jdisp_result_if: handshake channel for result words of the job dispatcher
// depends on jdisp_pkg for field widths

interface jdisp_result_if import jdisp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [JOB_W-1:0]    out_job;
	logic [WORKER_W-1:0] out_worker;
	logic                last;

	modport source (output valid, output status, output out_job, output out_worker,
		output last, input ready);
	modport sink (input valid, input status, input out_job, input out_worker,
		input last, output ready);
endinterface

// ===== hdl/jdisp_datapath.sv =====
// jdisp_datapath: job queue, idle worker stack, counters, pass index and output register
// depends on jdisp_pkg; driven by jdisp_ctrl through cmd_t, reports through sts_t

module jdisp_datapath import jdisp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic [ACTION_W-1:0] item_action,
	input  logic [JOB_W-1:0]    item_job_id,
	input  logic [WORKER_W-1:0] item_worker,
	input  logic                res_ready,
	output logic                res_valid,
	output logic [STATUS_W-1:0] res_status,
	output logic [JOB_W-1:0]    res_job,
	output logic [WORKER_W-1:0] res_worker,
	output logic                res_last,
	input  cmd_t                cmd,
	output sts_t                sts
);

	logic [ACTION_W-1:0] act_q;
	logic [JOB_W-1:0]    job_q;
	logic [WORKER_W-1:0] wkr_q;
	logic [JOB_W-1:0]    hold_q;
	logic [QCW-1:0]      idx_q;
	logic                found_q;
	logic [JOB_W-1:0]    queue_q [QUEUE_DEPTH];
	logic [QCW-1:0]      qcnt_q;
	logic [WORKER_W-1:0] stack_q [MAX_WORKERS];
	logic [ICW-1:0]      icnt_q;
	logic                dying_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [JOB_W-1:0]    out_job_q;
	logic [WORKER_W-1:0] out_worker_q;
	logic                out_last_q;

	logic [JOB_W-1:0]    q_rd;
	logic [QCW-1:0]      idx_prev;
	logic [ICW-1:0]      icnt_dec;
	logic [WORKER_W-1:0] stack_top;
	logic                idle_full;
	logic                out_free;
	logic                reload;
	logic [JOB_W-1:0]    job_mux;
	logic [WORKER_W-1:0] worker_mux;

	assign q_rd      = queue_q[idx_q[QIW-1:0]];
	assign idx_prev  = idx_q - 1'b1;
	assign icnt_dec  = icnt_q - 1'b1;
	assign stack_top = stack_q[icnt_dec[SIW-1:0]];
	assign idle_full = (icnt_q == ICW'(MAX_WORKERS));
	assign out_free  = !out_valid_q || res_ready;
	assign reload    = cfg_we && (cfg_data != '0);

	always_comb begin
		unique case (cmd.res_job_sel)
			JSEL_ITEM:  job_mux = job_q;
			JSEL_QUEUE: job_mux = q_rd;
			JSEL_HOLD:  job_mux = hold_q;
			default:    job_mux = '0;
		endcase
		unique case (cmd.res_worker_sel)
			WSEL_ITEM:  worker_mux = wkr_q;
			WSEL_STACK: worker_mux = stack_top;
			default:    worker_mux = '0;
		endcase
	end

	always_comb begin
		sts.action      = action_t'(act_q);
		sts.job_zero    = (job_q == '0);
		sts.dying       = dying_q;
		sts.idle_empty  = (icnt_q == '0);
		sts.queue_full  = (qcnt_q == QCW'(QUEUE_DEPTH));
		sts.queue_empty = (qcnt_q == '0);
		sts.walk_end    = (idx_q == qcnt_q);
		sts.found       = found_q;
		sts.match       = (q_rd == job_q);
		sts.out_free    = out_free;
	end

	// control state and idle stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q      <= '0;
			icnt_q      <= ICW'(MAX_WORKERS);
			dying_q     <= 1'b0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_WORKERS; i++) begin
				stack_q[i] <= WORKER_W'(i);
			end
		end else begin
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (reload) begin
				// clamp to pool size
				if (32'(cfg_data) > MAX_WORKERS) begin
					icnt_q <= ICW'(MAX_WORKERS);
				end else begin
					icnt_q <= ICW'(cfg_data);
				end
				qcnt_q  <= '0;
				dying_q <= 1'b0;
				for (int i = 0; i < MAX_WORKERS; i++) begin
					stack_q[i] <= WORKER_W'(i);
				end
			end else begin
				if (cmd.pop_idle) begin
					icnt_q <= icnt_dec;
				end else if (cmd.push_idle && !idle_full) begin
					stack_q[icnt_q[SIW-1:0]] <= wkr_q;
					icnt_q <= icnt_q + 1'b1;
				end
				if (cmd.cnt_clear) begin
					qcnt_q <= '0;
				end else if (cmd.enqueue) begin
					qcnt_q <= qcnt_q + 1'b1;
				end else if (cmd.cnt_dec) begin
					qcnt_q <= qcnt_q - 1'b1;
				end
				if (cmd.set_dying) begin
					dying_q <= 1'b1;
				end
				if (cmd.walk_init) begin
					idx_q   <= cmd.init_idx_one ? QCW'(1) : '0;
					found_q <= cmd.init_found;
				end else begin
					if (cmd.walk_step) begin
						idx_q <= idx_q + 1'b1;
					end
					if (cmd.set_found) begin
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	// payload: captured word, queue entries, result fields
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q <= item_action;
			job_q <= item_job_id;
			wkr_q <= item_worker;
		end
		if (cmd.hold_capture) begin
			hold_q <= queue_q[0];
		end
		if (cmd.enqueue) begin
			queue_q[qcnt_q[QIW-1:0]] <= job_q;
		end else if (cmd.shift_write) begin
			queue_q[idx_prev[QIW-1:0]] <= q_rd;
		end
		if (cmd.res_load) begin
			out_status_q <= cmd.res_status;
			out_job_q    <= job_mux;
			out_worker_q <= worker_mux;
			out_last_q   <= cmd.res_last;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_status = out_status_q;
	assign res_job    = out_job_q;
	assign res_worker = out_worker_q;
	assign res_last   = out_last_q;

endmodule

// ===== hdl/jdisp_ctrl.sv =====
// jdisp_ctrl: state machine that sequences one input word at a time
// depends on jdisp_pkg; drives jdisp_datapath through cmd_t

module jdisp_ctrl import jdisp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_WALK = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.action)
					ACT_ADD: begin
						if (sts.out_free) begin
							cmd.res_load    = 1'b1;
							cmd.res_last    = 1'b1;
							cmd.res_job_sel = JSEL_ITEM;
							state_d         = S_IDLE;
							priority if (sts.job_zero) begin
								cmd.res_status  = STS_INVALID;
								cmd.res_job_sel = JSEL_NONE;
							end else if (sts.dying) begin
								cmd.res_status = STS_ABANDONED;
							end else if (!sts.idle_empty) begin
								cmd.res_status     = STS_DISPATCHED;
								cmd.res_worker_sel = WSEL_STACK;
								cmd.pop_idle       = 1'b1;
							end else if (!sts.queue_full) begin
								cmd.res_status = STS_QUEUED;
								cmd.enqueue    = 1'b1;
							end else begin
								cmd.res_status = STS_FULL;
							end
						end
					end
					ACT_RETRACT: begin
						if (sts.job_zero || sts.dying) begin
							if (sts.out_free) begin
								cmd.res_load    = 1'b1;
								cmd.res_last    = 1'b1;
								cmd.res_status  = sts.job_zero ? STS_INVALID : STS_IGNORED;
								cmd.res_job_sel = sts.job_zero ? JSEL_NONE : JSEL_ITEM;
								state_d         = S_IDLE;
							end
						end else begin
							cmd.walk_init = 1'b1;
							state_d       = S_WALK;
						end
					end
					ACT_RETURN: begin
						if (!sts.dying && !sts.queue_empty) begin
							// head leaves, rest of the queue moves down
							cmd.walk_init    = 1'b1;
							cmd.init_idx_one = 1'b1;
							cmd.init_found   = 1'b1;
							cmd.hold_capture = 1'b1;
							state_d          = S_WALK;
						end else if (sts.out_free) begin
							cmd.res_load       = 1'b1;
							cmd.res_last       = 1'b1;
							cmd.res_status     = STS_IDLE;
							cmd.res_worker_sel = WSEL_ITEM;
							cmd.push_idle      = 1'b1;
							state_d            = S_IDLE;
						end
					end
					default: begin
						cmd.set_dying = 1'b1;
						cmd.walk_init = 1'b1;
						state_d       = S_WALK;
					end
				endcase
			end
			S_WALK: begin
				if (sts.walk_end) begin
					if (sts.out_free) begin
						cmd.res_load = 1'b1;
						cmd.res_last = 1'b1;
						state_d      = S_IDLE;
						unique case (sts.action)
							ACT_RETRACT: begin
								cmd.res_status  = sts.found ? STS_RETRACTED : STS_NOT_FOUND;
								cmd.res_job_sel = JSEL_ITEM;
								cmd.cnt_dec     = sts.found;
							end
							ACT_RETURN: begin
								cmd.res_status     = STS_DISPATCHED;
								cmd.res_job_sel    = JSEL_HOLD;
								cmd.res_worker_sel = WSEL_ITEM;
								cmd.cnt_dec        = 1'b1;
							end
							default: begin
								cmd.res_status = STS_SHUTDOWN;
								cmd.cnt_clear  = 1'b1;
							end
						endcase
					end
				end else if (sts.action == ACT_SHUTDOWN) begin
					if (sts.out_free) begin
						cmd.res_load    = 1'b1;
						cmd.res_status  = STS_ABANDONED;
						cmd.res_job_sel = JSEL_QUEUE;
						cmd.walk_step   = 1'b1;
					end
				end else begin
					cmd.walk_step = 1'b1;
					if (sts.found) begin
						cmd.shift_write = 1'b1;
					end else if (sts.match) begin
						cmd.set_found = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/job_dispatcher_with_idle_worker_pool.sv =====
// job_dispatcher_with_idle_worker_pool: top level of the job dispatcher
// depends on jdisp_pkg, jdisp_item_if, jdisp_result_if, jdisp_ctrl, jdisp_datapath

// Hands job ids to a pool of workers. Jobs wait in a first-in, first-out queue of
// QUEUE_DEPTH entries, idle workers sit on a last-in, first-out stack, and a shutdown
// word makes every later add come back abandoned until num_workers is written again.
// One input word is handled at a time: ready is high only between words. Retract and
// shutdown walk the queue one entry per cycle, a shutdown only while the output
// register is free or being emptied; a return that takes the head job moves the
// remaining entries down. Shutdown gives one abandoned word per queued job and then
// a shutdown-done word, the last word of every input carrying last. A result waiting
// in the output register with result.ready low stalls the block wherever it must
// load a result. A num_workers write is registered and must come only while the
// block is between words and the last result has been taken; zero is ignored and
// values above MAX_WORKERS are clamped.

module job_dispatcher_with_idle_worker_pool import jdisp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_data,
	jdisp_item_if.sink            item,
	jdisp_result_if.source        result
);

	cmd_t cmd;
	sts_t sts;
	logic item_ready;

	assign item.ready = item_ready;

	// sequencing of each word
	jdisp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// queue, idle stack and output register
	jdisp_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.item_action (item.action),
		.item_job_id (item.job_id),
		.item_worker (item.worker),
		.res_ready   (result.ready),
		.res_valid   (result.valid),
		.res_status  (result.status),
		.res_job     (result.out_job),
		.res_worker  (result.out_worker),
		.res_last    (result.last),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

// ===== hdl/jdisp_checker.sv =====
// jdisp_checker: port-level assertions for the job dispatcher, bound to the top level
// depends on jdisp_pkg for status codes

module jdisp_checker import jdisp_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                res_valid,
	input logic                res_ready,
	input logic [STATUS_W-1:0] res_status,
	input logic [JOB_W-1:0]    res_job,
	input logic [WORKER_W-1:0] res_worker,
	input logic                res_last
);

	// one word in flight: no second acceptance right after one
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("word accepted back to back");

	// only abandoned words can be followed by more words of the same input
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status != STS_ABANDONED) |-> res_last)
		else $error("result without last flag");

	// invalid results carry no job and no worker
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status == STS_INVALID) |-> (res_job == '0 && res_worker == '0))
		else $error("invalid result carries data");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_status) &&
			$stable(res_job) && $stable(res_worker) && $stable(res_last)))
		else $error("stalled result changed");

endmodule

bind job_dispatcher_with_idle_worker_pool jdisp_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_status (result.status),
	.res_job    (result.out_job),
	.res_worker (result.out_worker),
	.res_last   (result.last)
);

// ===== sim/jdisp_dispatch_monitor.sv =====
// jdisp_dispatch_monitor: keeps its own copy of the dispatcher state, predicts every result
// word from the accepted job words and compares it with the result channel
// depends on jdisp_pkg, jdisp_item_if and jdisp_result_if

module jdisp_dispatch_monitor import jdisp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	jdisp_item_if            item,
	jdisp_result_if          result,
	output int               pending,
	output int               fails,
	output int               words_checked
);

	typedef struct packed {
		status_t             status;
		logic [JOB_W-1:0]    job;
		logic [WORKER_W-1:0] worker;
		logic                last;
	} outcome_t;

	logic [JOB_W-1:0]    waiting_jobs[$];
	logic [WORKER_W-1:0] idle_pool[MAX_WORKERS];
	int                  idle_depth;
	logic                shutting_down;
	outcome_t            due_outcomes[$];
	int                  fail_total;
	int                  checked_total;

	function automatic void reload_pool(input logic [CFG_W-1:0] n);
		int pool_size;
		pool_size = int'(n);
		if (pool_size == 0) begin
			return;
		end
		if (pool_size > MAX_WORKERS) begin
			pool_size = MAX_WORKERS;
		end
		for (int i = 0; i < MAX_WORKERS; i++) begin
			idle_pool[i] = WORKER_W'(i);
		end
		idle_depth = pool_size;
		waiting_jobs.delete();
		shutting_down = 1'b0;
	endfunction

	function automatic void push_outcome(input status_t st, input logic [JOB_W-1:0] job,
		input logic [WORKER_W-1:0] wrk);
		outcome_t o;
		o.status = st;
		o.job    = job;
		o.worker = wrk;
		o.last   = 1'b0;
		due_outcomes = {due_outcomes, o};
	endfunction

	function automatic void dispatch_outcomes(input action_t act, input logic [JOB_W-1:0] job,
		input logic [WORKER_W-1:0] wrk);
		int               hit;
		logic [JOB_W-1:0] head;
		outcome_t         tail;
		case (act)
		ACT_ADD: begin
			if (job == '0) begin
				push_outcome(STS_INVALID, '0, '0);
			end else if (shutting_down) begin
				push_outcome(STS_ABANDONED, job, '0);
			end else if (idle_depth > 0) begin
				idle_depth--;
				push_outcome(STS_DISPATCHED, job, idle_pool[idle_depth]);
			end else if (waiting_jobs.size() < QUEUE_DEPTH) begin
				waiting_jobs = {waiting_jobs, job};
				push_outcome(STS_QUEUED, job, '0);
			end else begin
				push_outcome(STS_FULL, job, '0);
			end
		end
		ACT_RETRACT: begin
			if (job == '0) begin
				push_outcome(STS_INVALID, '0, '0);
			end else if (shutting_down) begin
				push_outcome(STS_IGNORED, job, '0);
			end else begin
				hit = -1;
				foreach (waiting_jobs[i]) begin
					if (hit < 0 && waiting_jobs[i] == job) begin
						hit = i;
					end
				end
				if (hit >= 0) begin
					waiting_jobs.delete(hit);
					push_outcome(STS_RETRACTED, job, '0);
				end else begin
					push_outcome(STS_NOT_FOUND, job, '0);
				end
			end
		end
		ACT_RETURN: begin
			if (!shutting_down && waiting_jobs.size() > 0) begin
				head = waiting_jobs[0];
				waiting_jobs.delete(0);
				push_outcome(STS_DISPATCHED, head, wrk);
			end else begin
				// a full idle stack drops the worker but still reports it idle
				if (idle_depth < MAX_WORKERS) begin
					idle_pool[idle_depth] = wrk;
					idle_depth++;
				end
				push_outcome(STS_IDLE, '0, wrk);
			end
		end
		ACT_SHUTDOWN: begin
			shutting_down = 1'b1;
			foreach (waiting_jobs[i]) begin
				push_outcome(STS_ABANDONED, waiting_jobs[i], '0);
			end
			waiting_jobs.delete();
			push_outcome(STS_SHUTDOWN, '0, '0);
		end
		default: begin
		end
		endcase
		tail = due_outcomes[due_outcomes.size() - 1];
		tail.last = 1'b1;
		due_outcomes[due_outcomes.size() - 1] = tail;
	endfunction

	// results are compared before the new job word is predicted, so a word
	// arriving with an empty store is flagged even if a job lands on the same edge
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			due_outcomes.delete();
			reload_pool(CFG_W'(MAX_WORKERS));
			fail_total    = 0;
			checked_total = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (due_outcomes.size() == 0) begin
					$error("unexpected result word: status %0d job %0d worker %0d",
						result.status, result.out_job, result.out_worker);
					fail_total++;
				end else begin
					want = due_outcomes[0];
					due_outcomes.delete(0);
					checked_total++;
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_total++;
					end
					if (result.out_job !== want.job) begin
						$error("out_job: expected %0d, got %0d", want.job, result.out_job);
						fail_total++;
					end
					if (result.out_worker !== want.worker) begin
						$error("out_worker: expected %0d, got %0d", want.worker,
							result.out_worker);
						fail_total++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, result.last);
						fail_total++;
					end
				end
			end
			if (item.valid && item.ready) begin
				dispatch_outcomes(action_t'(item.action), item.job_id, item.worker);
			end
			if (cfg_we) begin
				reload_pool(cfg_data);
			end
		end
		pending       <= due_outcomes.size();
		fails         <= fail_total;
		words_checked <= checked_total;
	end

endmodule

// ===== sim/job_dispatcher_with_idle_worker_pool_tb.sv =====
// job_dispatcher_with_idle_worker_pool_tb: drives job words and result backpressure into the
// dispatcher, with jdisp_dispatch_monitor beside it doing prediction and comparison
// depends on jdisp_pkg, jdisp_item_if, jdisp_result_if, jdisp_dispatch_monitor and the block

module job_dispatcher_with_idle_worker_pool_tb;
	import jdisp_pkg::*;

	localparam int STALL_LIMIT = 4000;  // cycles with no word moving on either channel
	localparam int RX_HOLD     = 300;   // long result stall, far past what fills the block
	localparam int PHASES      = 7;
	localparam int PHASE_WORDS = 43;
	localparam int SETTLE      = 40;    // quiet cycles at the end to catch stray results

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_data;

	int pending;
	int fails;
	int words_checked;

	// idle rates in percent, one for the job sender and one for the result receiver
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_req;        // bumped to ask the receiver for one long stall
	int words_sent;
	int settings_used;

	jdisp_item_if   item_ch();
	jdisp_result_if result_ch();

	job_dispatcher_with_idle_worker_pool u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	jdisp_dispatch_monitor u_dispatch_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.item          (item_ch),
		.result        (result_ch),
		.pending       (pending),
		.fails         (fails),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// offer one job word, idling first at the sender's rate; valid stays high
	// after acceptance so back-to-back words never drop it within one step
	task automatic send_job(input action_t act, input logic [JOB_W-1:0] job,
		input logic [WORKER_W-1:0] wrk);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid  <= 1'b1;
		item_ch.action <= act;
		item_ch.job_id <= job;
		item_ch.worker <= wrk;
		do @(posedge clk); while (!item_ch.ready);
		words_sent++;
	endtask

	// stop offering and wait until the monitor holds no outstanding result;
	// every job word yields at least one result, so the block is then between words
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_pool_size(input logic [CFG_W-1:0] n);
		drain_results();
		cfg_we   <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		cfg_we   <= 1'b0;
		settings_used++;
	endtask

	// mostly a small id range so retracts hit and duplicates occur,
	// sometimes the full 16-bit range, rarely the invalid zero id
	function automatic logic [JOB_W-1:0] pick_job();
		int r;
		r = $urandom_range(99);
		if (r < 4) begin
			return '0;
		end else if (r < 14) begin
			return JOB_W'($urandom_range(65535));
		end
		return JOB_W'($urandom_range(24, 1));
	endfunction

	// shutdown is rare since it turns the rest of a phase into abandons
	function automatic action_t pick_action(input int add_pct);
		int r;
		int rest;
		r    = $urandom_range(99);
		rest = 98 - add_pct;
		if (r < 2) begin
			return ACT_SHUTDOWN;
		end else if (r < 2 + add_pct) begin
			return ACT_ADD;
		end else if (r < 2 + add_pct + rest * 2 / 5) begin
			return ACT_RETRACT;
		end
		return ACT_RETURN;
	endfunction

	// result receiver: random ready, or a long stall counted here when asked
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = RX_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// watchdog: ends the run when neither channel moves a word for too long
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("watchdog: %0d cycles without a word moving", STALL_LIMIT);
		$display("job_dispatcher_with_idle_worker_pool regression: fail");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] pool_cfg[PHASES];
		int               add_pct;
		action_t          act;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_data       <= '0;
		item_ch.valid  <= 1'b0;
		item_ch.action <= ACT_ADD;
		item_ch.job_id <= '0;
		item_ch.worker <= '0;
		tx_idle_pct   = 10;
		rx_idle_pct   = 88;
		hold_req      = 0;
		words_sent    = 0;
		settings_used = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		// out of reset all eight workers are idle, so this return finds the stack full
		send_job(ACT_RETURN, '0, 3'd7);
		write_pool_size(4'd1);
		send_job(ACT_ADD, '0, '0);              // zero id on add
		send_job(ACT_RETRACT, '0, '0);          // zero id on retract
		send_job(ACT_ADD, 16'hffff, 3'd7);      // the only worker takes it
		send_job(ACT_ADD, 16'd1, '0);
		send_job(ACT_ADD, 16'd1, '0);           // duplicate id queued behind the first
		send_job(ACT_ADD, 16'h8000, '0);
		send_job(ACT_RETRACT, 16'd1, '0);       // oldest copy leaves, the gap closes
		send_job(ACT_RETRACT, 16'h1234, '0);    // not in the queue
		send_job(ACT_RETURN, '0, 3'd7);         // returning worker takes the head job
		send_job(ACT_RETURN, 16'hffff, 3'd0);
		send_job(ACT_RETURN, '0, 3'd5);         // queue empty, worker goes idle
		send_job(ACT_ADD, 16'd2, '0);
		send_job(ACT_ADD, 16'd3, '0);
		send_job(ACT_ADD, 16'd4, '0);
		send_job(ACT_SHUTDOWN, 16'hffff, 3'd7); // abandons both queued jobs in order
		send_job(ACT_ADD, 16'hffff, '0);        // add while shutting down
		send_job(ACT_ADD, '0, '0);
		send_job(ACT_RETRACT, 16'd3, '0);       // retract while shutting down
		send_job(ACT_RETURN, '0, 3'd2);         // return while shutting down
		send_job(ACT_SHUTDOWN, '0, '0);         // second shutdown, nothing left to abandon
		write_pool_size(4'd15);                 // clamps to the full pool
		write_pool_size(4'd0);                  // ignored, pool stays at eight
		send_job(ACT_ADD, 16'h5555, '0);

		// random part: one pool size per phase, small pools fill the queue
		pool_cfg = '{4'd1, 4'd8, 4'd2, 4'd15, 4'd3, 4'd0, 4'd6};
		pool_cfg[PHASES - 1] = CFG_W'($urandom_range(8, 1));
		for (int p = 0; p < PHASES; p++) begin
			// sender and receiver swap idle rates, then neither idles
			if (p == 2) begin
				tx_idle_pct = 88;
				rx_idle_pct = 10;
			end
			if (p == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_pool_size(pool_cfg[p]);
			add_pct = (pool_cfg[p] != 0 && pool_cfg[p] <= 3) ? 60 : 45;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				// long result stall while jobs keep coming, so the block backs up
				if (p == 4 && k == 10) begin
					hold_req++;
				end
				// sender goes quiet until every result is in
				if (p == 2 && k == 20) begin
					drain_results();
				end
				// with a tiny pool a run of adds overflows the queue, and a later
				// shutdown then abandons a deep queue
				if ((p == 0 || p == 4) && k < 20) begin
					act = ACT_ADD;
				end else if ((p == 0 || p == 4) && k == 20) begin
					act = ACT_SHUTDOWN;
				end else begin
					act = pick_action(add_pct);
				end
				send_job(act, pick_job(), WORKER_W'($urandom_range(7)));
			end
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d job words, checked %0d result words across %0d pool size writes",
			words_sent, words_checked, settings_used);
		$display("covered zero ids, duplicate retracts, full queue and idle stack, shutdown,"
			, " and a long result stall");
		if (fails == 0) begin
			$display("job_dispatcher_with_idle_worker_pool regression: pass");
		end else begin
			$display("job_dispatcher_with_idle_worker_pool regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/jdisp_pkg.sv
hdl/jdisp_item_if.sv
hdl/jdisp_result_if.sv
hdl/jdisp_datapath.sv
hdl/jdisp_ctrl.sv
hdl/job_dispatcher_with_idle_worker_pool.sv
hdl/jdisp_checker.sv
sim/jdisp_dispatch_monitor.sv
sim/job_dispatcher_with_idle_worker_pool_tb.sv
